FILE: rtl/pcbp_pkg.sv
// Shared constants, types and state encodings for the partition counter.
package pcbp_pkg;

    localparam int DEF_MAX_AMOUNT = 255;
    localparam int AMT_W          = 8;
    localparam int CMD_W          = 2;
    localparam int COUNT_W        = 63;
    localparam int QDEPTH         = 2;

    localparam logic [CMD_W-1:0] CMD_ALL   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UPTO  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RANGE = 2'd2;

    // One classified query: either a direct result (0 or 1) or a row-sum job.
    typedef struct packed {
        logic             direct;
        logic             one;
        logic [AMT_W-1:0] row;
        logic [AMT_W-1:0] lo;
        logic [AMT_W-1:0] hi;
    } job_t;

    typedef enum logic [1:0] {
        TBL_FILL,
        TBL_DRAIN,
        TBL_READY
    } tbl_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DRAIN,
        BK_DONE
    } bk_state_t;

endpackage

FILE: rtl/pcbp_front.sv
// Front end: input handshake and query classification into a row-sum job.
module pcbp_front
    import pcbp_pkg::*;
#(
    parameter int MAX_AMOUNT = DEF_MAX_AMOUNT
)
(
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [CMD_W-1:0] command,
    input  logic [AMT_W-1:0] amount,
    input  logic [AMT_W-1:0] min_parts,
    input  logic [AMT_W-1:0] max_parts,
    input  logic             tbl_ready,
    input  logic             q_full,
    output logic             push,
    output job_t             job
);

    localparam logic [AMT_W:0] MaxAmt = (AMT_W+1)'(MAX_AMOUNT);

    logic [AMT_W-1:0] hi_clamp;
    logic             beyond;

    assign in_stall = !tbl_ready || q_full;
    assign push     = in_valid && !in_stall;

    always_comb
    begin
        hi_clamp   = (max_parts > amount) ? amount : max_parts;
        beyond     = {1'b0, amount} > MaxAmt;
        job.direct = 1'b1;
        job.one    = 1'b0;
        job.row    = amount;
        job.lo     = '0;
        job.hi     = '0;
        if (!beyond)
        begin
            if (amount == '0)
            begin
                case (command)
                    CMD_ALL, CMD_UPTO: job.one = 1'b1;
                    // empty partition counted only for ranges 0..0 and 0..1
                    CMD_RANGE: job.one = (min_parts == '0) && (max_parts <= AMT_W'(1));
                    default:   job.one = 1'b0;
                endcase
            end
            else
            begin
                case (command)
                    CMD_ALL:
                    begin
                        job.direct = 1'b0;
                        job.lo     = AMT_W'(1);
                        job.hi     = amount;
                    end
                    CMD_UPTO:
                    begin
                        if (hi_clamp != '0)
                        begin
                            job.direct = 1'b0;
                            job.lo     = AMT_W'(1);
                            job.hi     = hi_clamp;
                        end
                    end
                    CMD_RANGE:
                    begin
                        if (!(min_parts > amount) && !(min_parts > hi_clamp))
                        begin
                            job.direct = 1'b0;
                            job.lo     = min_parts;
                            job.hi     = hi_clamp;
                        end
                    end
                    default: job.direct = 1'b1;
                endcase
            end
        end
    end

endmodule

FILE: rtl/pcbp_queue.sv
// Small job queue between the front end and the summing back end.
module pcbp_queue
    import pcbp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t wdata,
    input  logic pop,
    output job_t rdata,
    output logic full,
    output logic empty
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    job_t             slot_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] level_reg, level_next;

    assign rdata = slot_reg[rd_ptr_reg];
    assign full  = (level_reg == CNT_W'(QDEPTH));
    assign empty = (level_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            level_next = level_reg + CNT_W'(1);
        else if (pop && !push)
            level_next = level_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

FILE: rtl/pcbp_table.sv
// Table memory P(i,j) with its post-reset build pass and one query read port.
module pcbp_table
    import pcbp_pkg::*;
#(
    parameter int MAX_AMOUNT = DEF_MAX_AMOUNT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    output logic                                 ready,
    input  logic [$clog2(MAX_AMOUNT+1)-1:0]      rd_row,
    input  logic [$clog2(MAX_AMOUNT+1)-1:0]      rd_col,
    output logic [COUNT_W-1:0]                   rd_data
);

    localparam int IDX_W  = $clog2(MAX_AMOUNT + 1);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam logic [IDX_W-1:0] LastIdx = IDX_W'(MAX_AMOUNT);

    logic [COUNT_W-1:0] mem [DEPTH];

    tbl_state_t         state_reg, state_next;
    logic [IDX_W-1:0]   fi_reg, fi_next;
    logic [IDX_W-1:0]   fj_reg, fj_next;
    logic               wr_vld_reg, wr_vld_next;
    logic               wr_sum_reg, wr_sum_next;
    logic               wr_one_reg, wr_one_next;
    logic [ADDR_W-1:0]  wr_addr_reg;
    logic [ADDR_W-1:0]  addr_a, addr_b;
    logic [COUNT_W-1:0] q_a_reg, q_b_reg;
    logic [COUNT_W-1:0] wr_data;

    assign ready   = (state_reg == TBL_READY);
    assign rd_data = q_a_reg;
    assign wr_data = wr_sum_reg ? (q_a_reg + q_b_reg) : COUNT_W'(wr_one_reg);

    // Build order is row-major; both operands sit in earlier rows,
    // at least one row back, so the write has landed.
    always_comb
    begin
        state_next  = state_reg;
        fi_next     = fi_reg;
        fj_next     = fj_reg;
        wr_vld_next = 1'b0;
        wr_sum_next = 1'b0;
        wr_one_next = 1'b0;
        addr_a      = {rd_row, rd_col};
        addr_b      = '0;
        case (state_reg)
            TBL_FILL:
            begin
                wr_vld_next = 1'b1;
                wr_one_next = (fi_reg == '0) && (fj_reg == '0);
                wr_sum_next = (fi_reg != '0) && (fj_reg != '0) && (fj_reg <= fi_reg);
                addr_a      = {fi_reg - IDX_W'(1), fj_reg - IDX_W'(1)};
                addr_b      = {fi_reg - fj_reg, fj_reg};
                if (fj_reg == LastIdx)
                begin
                    fj_next = '0;
                    if (fi_reg == LastIdx)
                        state_next = TBL_DRAIN;
                    else
                        fi_next = fi_reg + IDX_W'(1);
                end
                else
                begin
                    fj_next = fj_reg + IDX_W'(1);
                end
            end
            TBL_DRAIN: state_next = TBL_READY;
            TBL_READY: state_next = TBL_READY;
            default:   state_next = TBL_FILL;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_vld_reg)
            mem[wr_addr_reg] <= wr_data;
        q_a_reg     <= mem[addr_a];
        q_b_reg     <= mem[addr_b];
        wr_addr_reg <= {fi_reg, fj_reg};
        wr_sum_reg  <= wr_sum_next;
        wr_one_reg  <= wr_one_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= TBL_FILL;
            fi_reg     <= '0;
            fj_reg     <= '0;
            wr_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fi_reg     <= fi_next;
            fj_reg     <= fj_next;
            wr_vld_reg <= wr_vld_next;
        end
    end

endmodule

FILE: rtl/pcbp_back.sv
// Back end: row sum over the part range or a direct result, held for output.
module pcbp_back
    import pcbp_pkg::*;
#(
    parameter int MAX_AMOUNT = DEF_MAX_AMOUNT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_empty,
    input  job_t                             job,
    output logic                             pop,
    output logic [$clog2(MAX_AMOUNT+1)-1:0]  rd_row,
    output logic [$clog2(MAX_AMOUNT+1)-1:0]  rd_col,
    input  logic [COUNT_W-1:0]               rd_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [COUNT_W-1:0]               count
);

    localparam int IDX_W = $clog2(MAX_AMOUNT + 1);

    bk_state_t          state_reg, state_next;
    logic [IDX_W-1:0]   row_reg, row_next;
    logic [AMT_W-1:0]   col_reg, col_next;
    logic [AMT_W-1:0]   hi_reg, hi_next;
    logic [COUNT_W-1:0] acc_reg, acc_next;
    logic               rd_vld_reg, rd_vld_next;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;

    assign rd_row    = row_reg;
    assign rd_col    = IDX_W'(col_reg);
    assign out_valid = out_valid_reg;
    assign count     = out_count_reg;

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        hi_next        = hi_reg;
        pop            = 1'b0;
        rd_vld_next    = 1'b0;
        acc_next       = rd_vld_reg ? (acc_reg + rd_data) : acc_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_count_next = out_count_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    if (job.direct)
                    begin
                        acc_next   = COUNT_W'(job.one);
                        state_next = BK_DONE;
                    end
                    else
                    begin
                        acc_next   = '0;
                        row_next   = IDX_W'(job.row);
                        col_next   = job.lo;
                        hi_next    = job.hi;
                        state_next = BK_RUN;
                    end
                end
            end
            BK_RUN:
            begin
                rd_vld_next = 1'b1;
                if (col_reg == hi_reg)
                    state_next = BK_DRAIN;
                else
                    col_next = col_reg + AMT_W'(1);
            end
            // last read word is added this cycle
            BK_DRAIN: state_next = BK_DONE;
            BK_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = acc_reg;
                    state_next     = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        row_reg       <= row_next;
        col_reg       <= col_next;
        hi_reg        <= hi_next;
        acc_reg       <= acc_next;
        out_count_reg <= out_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/partition_count_by_parts.sv
// Top level of the partition counter: front end, job queue, table memory and back end.
//
// Each query transfer (command, amount, min_parts, max_parts) returns one count: the
// number of partitions of amount whose number of parts lies in the range picked by
// the command (0: any, 1: 1..max_parts, 2: min_parts..max_parts, max clamped to
// amount; command 3 or an amount above MAX_AMOUNT gives 0). The counts come from a
// table P(i,j) of partitions of i into exactly j parts, (MAX_AMOUNT+1)^2 words of
// 63 bits, held in an on-chip memory. After reset the table is built in place by
// P(i,j) = P(i-1,j-1) + P(i-j,j), one entry per cycle, and in_stall stays high
// until the build has finished. After that, a query whose range is lo..hi sums
// hi-lo+1 words of its row, one word per cycle through the single query read port
// of the table (at amount 255 a range starting at zero reads 256 words); trivial
// queries (zero amount, empty range) skip the row sum and give 0 or 1 directly. A
// two-entry queue between the classifier and the summing engine lets new queries
// be taken while a sum runs, and the result sits in an output register so the
// engine moves on without waiting for it to be taken.
module partition_count_by_parts
    import pcbp_pkg::*;
#(
    parameter int MAX_AMOUNT = DEF_MAX_AMOUNT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CMD_W-1:0]   command,
    input  logic [AMT_W-1:0]   amount,
    input  logic [AMT_W-1:0]   min_parts,
    input  logic [AMT_W-1:0]   max_parts,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COUNT_W-1:0] count
);

    localparam int IDX_W = $clog2(MAX_AMOUNT + 1);

    logic               tbl_ready;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    job_t               front_job;
    job_t               back_job;
    logic [IDX_W-1:0]   rd_row;
    logic [IDX_W-1:0]   rd_col;
    logic [COUNT_W-1:0] rd_data;

    // Classify the query; stall while the table builds or the queue is full.
    pcbp_front #(
        .MAX_AMOUNT(MAX_AMOUNT)
    ) u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .amount    (amount),
        .min_parts (min_parts),
        .max_parts (max_parts),
        .tbl_ready (tbl_ready),
        .q_full    (q_full),
        .push      (q_push),
        .job       (front_job)
    );

    pcbp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (front_job),
        .pop   (q_pop),
        .rdata (back_job),
        .full  (q_full),
        .empty (q_empty)
    );

    // Table memory; its query port belongs to the back end once built.
    pcbp_table #(
        .MAX_AMOUNT(MAX_AMOUNT)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .ready   (tbl_ready),
        .rd_row  (rd_row),
        .rd_col  (rd_col),
        .rd_data (rd_data)
    );

    pcbp_back #(
        .MAX_AMOUNT(MAX_AMOUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .job       (back_job),
        .pop       (q_pop),
        .rd_row    (rd_row),
        .rd_col    (rd_col),
        .rd_data   (rd_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .count     (count)
    );

    // No query may enter before the table build has finished.
    a_accept_after_build: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> tbl_ready)
        else $error("query transfer taken before table build finished");

    // Once built, the table stays usable.
    a_ready_holds: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_ready |=> tbl_ready)
        else $error("table ready dropped after build");

    // The back end only takes a job that is in the queue.
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job queue popped while empty");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for partition_count_by_parts: directed and random queries.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pcbp_pkg::*;

    // Table size and the one command code the package leaves unnamed.
    localparam int               MAX_AMT    = DEF_MAX_AMOUNT;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int               RANDOM_QUERIES = 800;
    // The block can still be summing a long row when the queue drains.
    localparam int               DRAIN_CYCLES   = 400;
    localparam int               REPORT_LIMIT   = 10;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [AMT_W-1:0] amt;
        logic [AMT_W-1:0] lo;
        logic [AMT_W-1:0] hi;
    } query_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [CMD_W-1:0]   command = '0;
    logic [AMT_W-1:0]   amount = '0;
    logic [AMT_W-1:0]   min_parts = '0;
    logic [AMT_W-1:0]   max_parts = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [COUNT_W-1:0] count;

    // Partitions of i into exactly j parts, built the same way the block builds its table.
    logic [COUNT_W-1:0] parts_tbl [0:MAX_AMT][0:MAX_AMT];

    query_t             pending_queries[$];
    logic [COUNT_W-1:0] expected_counts[$];
    query_t             next_query;
    int                 total_queries = 0;
    int                 directed_queries = 0;
    int                 sent_count = 0;
    int                 checked_count = 0;
    int                 mismatches = 0;
    int                 cmd_seen[4] = '{0, 0, 0, 0};
    int                 zero_counts = 0;

    partition_count_by_parts dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .amount    (amount),
        .min_parts (min_parts),
        .max_parts (max_parts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .count     (count)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Count of partitions of n whose number of parts falls in the range the command picks.
    function automatic logic [COUNT_W-1:0] count_in_range(logic [CMD_W-1:0] cmd,
                                                          logic [AMT_W-1:0] n,
                                                          logic [AMT_W-1:0] lo,
                                                          logic [AMT_W-1:0] hi);
        logic [63:0] total;
        int          first;
        int          last;
        total = '0;
        first = 1;
        last  = int'(n);
        if (cmd == CMD_UNUSED || int'(n) > MAX_AMT)
            total = '0;
        else if (n == 0)
        begin
            // zero amount: the range command only counts the empty partition for 0..0 or 0..1
            if (cmd == CMD_RANGE)
                total = (lo == 0 && hi <= 1) ? 64'd1 : 64'd0;
            else
                total = 64'd1;
        end
        else
        begin
            if (cmd != CMD_ALL)
            begin
                // max_parts is clamped to the amount
                last = (hi > n) ? int'(n) : int'(hi);
                if (cmd == CMD_RANGE)
                    first = int'(lo);
            end
            // an empty range (lo above the clamped hi, or hi of 0) leaves the sum at zero
            for (int j = first; j <= last; j++)
                total += parts_tbl[n][j];
        end
        return total[COUNT_W-1:0];
    endfunction

    // Random gaps: the sender idles lightly while the receiver stalls hard, then the
    // other way round, and in the last third of the run neither side holds back.
    function automatic bit roll_idle(int done, int light_pct, int heavy_pct, bit sender);
        int phase;
        int pct;
        phase = (total_queries > 0) ? (done * 3) / total_queries : 0;
        case (phase)
            0:       pct = sender ? light_pct : heavy_pct;
            1:       pct = sender ? heavy_pct : light_pct;
            default: pct = 0;
        endcase
        return $urandom_range(99) < pct;
    endfunction

    task automatic add_query(logic [CMD_W-1:0] cmd, int amt, int lo, int hi);
        query_t q;
        q.cmd = cmd;
        q.amt = amt[AMT_W-1:0];
        q.lo  = lo[AMT_W-1:0];
        q.hi  = hi[AMT_W-1:0];
        pending_queries.insert(pending_queries.size(), q);
    endtask

    task automatic note_mismatch(string what, logic [COUNT_W-1:0] want,
                                 logic [COUNT_W-1:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("[%0t] %s: expected count %0d, got %0d", $realtime, what, want, got);
    endtask

    // Driver: a query transfer completes on an edge with in_valid high and in_stall low.
    // The expected count is predicted from the payload at that edge. A new query (or an
    // idle cycle) is only chosen once the current one has gone, so the payload holds
    // steady under stall and valid never looks at stall.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_counts.insert(expected_counts.size(),
                                       count_in_range(command, amount, min_parts,
                                                      max_parts));
                cmd_seen[command]++;
                sent_count++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_queries.size() > 0 && !roll_idle(sent_count, 7, 65, 1'b1))
                begin
                    next_query = pending_queries.pop_front();
                    in_valid  <= 1'b1;
                    command   <= next_query.cmd;
                    amount    <= next_query.amt;
                    min_parts <= next_query.lo;
                    max_parts <= next_query.hi;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: every count transfer is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_counts.size() == 0)
                    note_mismatch("count with no query outstanding", '0, count);
                else
                begin
                    if (count !== expected_counts[0])
                        note_mismatch("count mismatch", expected_counts[0], count);
                    if (expected_counts[0] == 0)
                        zero_counts++;
                    void'(expected_counts.pop_front());
                end
                checked_count++;
            end
            out_stall <= roll_idle(checked_count, 7, 65, 1'b0);
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int a;
        int l;
        int h;
        int pick;
        logic [CMD_W-1:0] c;

        // Build the prediction table once.
        for (int i = 0; i <= MAX_AMT; i++)
        begin
            for (int j = 0; j <= MAX_AMT; j++)
            begin
                if (i == 0 && j == 0)
                    parts_tbl[i][j] = 1;
                else if (i >= 1 && j >= 1 && j <= i)
                    parts_tbl[i][j] = parts_tbl[i-1][j-1] + parts_tbl[i-j][j];
                else
                    parts_tbl[i][j] = '0;
            end
        end

        // Directed queries: zero amount under each command, the range quirk at zero,
        // the largest amount with full and single-entry ranges, clamping, empty ranges
        // and the unused command.
        add_query(CMD_ALL,    0,   0,   0);
        add_query(CMD_UPTO,   0,   0,   0);
        add_query(CMD_RANGE,  0,   0,   0);
        add_query(CMD_RANGE,  0,   0,   1);
        add_query(CMD_RANGE,  0,   0,   2);
        add_query(CMD_RANGE,  0,   1,   1);
        add_query(CMD_ALL,    1,   0,   0);
        add_query(CMD_RANGE,  1,   1,   1);
        add_query(CMD_ALL,    255, 255, 255);
        add_query(CMD_UPTO,   255, 0,   255);
        add_query(CMD_UPTO,   5,   0,   0);
        add_query(CMD_UPTO,   10,  0,   200);
        add_query(CMD_RANGE,  20,  21,  255);
        add_query(CMD_RANGE,  20,  10,  5);
        add_query(CMD_RANGE,  255, 0,   255);
        add_query(CMD_RANGE,  255, 255, 255);
        add_query(CMD_RANGE,  255, 1,   1);
        add_query(CMD_RANGE,  50,  0,   0);
        add_query(CMD_RANGE,  50,  0,   3);
        add_query(CMD_RANGE,  30,  30,  30);
        add_query(CMD_UNUSED, 100, 3,   50);
        add_query(CMD_UNUSED, 255, 255, 255);
        add_query(CMD_UNUSED, 0,   0,   0);
        directed_queries = pending_queries.size();

        // Random queries: mostly small amounts to keep row sums short, some full range.
        for (int k = 0; k < RANDOM_QUERIES; k++)
        begin
            pick = $urandom_range(19);
            if (pick == 0)
                c = CMD_UNUSED;
            else
                c = CMD_W'($urandom_range(2));
            pick = $urandom_range(9);
            if (pick == 0)
                a = 0;
            else if (pick < 7)
                a = $urandom_range(40);
            else
                a = $urandom_range(255);
            pick = $urandom_range(9);
            if (pick < 3)
            begin
                // any field value, exercises every bit and the out-of-range cases
                l = $urandom_range(255);
                h = $urandom_range(255);
            end
            else
            begin
                // mostly well-formed ranges, sometimes reaching past the amount
                l = $urandom_range(a);
                h = $urandom_range(l, (a + 3 > 255) ? 255 : a + 3);
            end
            add_query(c, a, l, h);
        end
        total_queries = pending_queries.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // The table fill after reset holds in_stall high, so just wait on the traffic.
        while (sent_count < total_queries || expected_counts.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (expected_counts.size() > 0)
            mismatches++;

        $display("Sent %0d queries (%0d directed): %0d all, %0d up-to, %0d range, %0d unused",
                 sent_count, directed_queries, cmd_seen[0], cmd_seen[1], cmd_seen[2],
                 cmd_seen[3]);
        $display("Checked %0d counts (%0d zero), %0d failures",
                 checked_count, zero_counts, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: table fill plus every query at its longest sum and stalls, several times over.
    initial
    begin
        #40_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
